@@ hw/rtl/fbgw_pkg.sv @@
// Shared constants, types and the 5x7 font table for the glyph writer.
`timescale 1ns / 1ps
`default_nettype none

package fbgw_pkg;

  localparam int SCREEN_WIDTH = 128;
  localparam int PAGE_COUNT   = 8;
  localparam int HALF_COLUMNS = 64;
  localparam int STORE_DEPTH  = SCREEN_WIDTH * PAGE_COUNT;
  localparam int ADDR_W       = $clog2(STORE_DEPTH);
  localparam int HC_W         = $clog2(HALF_COLUMNS);
  localparam int SC_W         = $clog2(2 * HALF_COLUMNS) + 1;
  localparam int GLYPH_COLS   = 5;
  localparam int FIRST_CODE   = 32;
  localparam int FONT_W       = 8 * GLYPH_COLS;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_PUT   = 2'd1,
    CMD_SEG   = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLEAR,
    S_DRAW,
    S_SEG_RD,
    S_SEG_OUT,
    S_DONE
  } state_e;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

  typedef struct packed {
    logic [7:0] pixel_byte;
    logic [2:0] page;
    logic       half;
    logic [5:0] column;
    logic       last;
  } res_t;

  // Byte address of a column within a page; callers use the result only for in-range values.
  function automatic logic [ADDR_W-1:0] store_addr(input logic [3:0] page,
                                                   input logic [8:0] col);
    return ADDR_W'(ADDR_W'(page) * ADDR_W'(SCREEN_WIDTH) + ADDR_W'(col));
  endfunction

  // Five glyph columns of one character, leftmost column in the top byte.
  function automatic logic [FONT_W-1:0] font_row(input logic [6:0] code);
    logic [FONT_W-1:0] row;
    case (code)
      7'd32:  row = 40'h0000000000;
      7'd33:  row = 40'h00005F0000;
      7'd34:  row = 40'h0007000700;
      7'd35:  row = 40'h147F147F14;
      7'd36:  row = 40'h242A7F2A12;
      7'd37:  row = 40'h2313086462;
      7'd38:  row = 40'h3649552250;
      7'd39:  row = 40'h0005030000;
      7'd40:  row = 40'h001C224100;
      7'd41:  row = 40'h0041221C00;
      7'd42:  row = 40'h082A1C2A08;
      7'd43:  row = 40'h08083E0808;
      7'd44:  row = 40'h0050300000;
      7'd45:  row = 40'h0808080808;
      7'd46:  row = 40'h0060600000;
      7'd47:  row = 40'h2010080402;
      7'd48:  row = 40'h3E5149453E;
      7'd49:  row = 40'h00427F4000;
      7'd50:  row = 40'h4261514946;
      7'd51:  row = 40'h2141454B31;
      7'd52:  row = 40'h1814127F10;
      7'd53:  row = 40'h2745454539;
      7'd54:  row = 40'h3C4A494930;
      7'd55:  row = 40'h0171090503;
      7'd56:  row = 40'h3649494936;
      7'd57:  row = 40'h064949291E;
      7'd58:  row = 40'h0036360000;
      7'd59:  row = 40'h0056360000;
      7'd60:  row = 40'h0008142241;
      7'd61:  row = 40'h1414141414;
      7'd62:  row = 40'h4122140800;
      7'd63:  row = 40'h0201510906;
      7'd64:  row = 40'h324979413E;
      7'd65:  row = 40'h7E1111117E;
      7'd66:  row = 40'h7F49494936;
      7'd67:  row = 40'h3E41414122;
      7'd68:  row = 40'h7F4141221C;
      7'd69:  row = 40'h7F49494941;
      7'd70:  row = 40'h7F09090101;
      7'd71:  row = 40'h3E41415132;
      7'd72:  row = 40'h7F0808087F;
      7'd73:  row = 40'h00417F4100;
      7'd74:  row = 40'h2040413F01;
      7'd75:  row = 40'h7F08142241;
      7'd76:  row = 40'h7F40404040;
      7'd77:  row = 40'h7F0204027F;
      7'd78:  row = 40'h7F0408107F;
      7'd79:  row = 40'h3E4141413E;
      7'd80:  row = 40'h7F09090906;
      7'd81:  row = 40'h3E4151215E;
      7'd82:  row = 40'h7F09192946;
      7'd83:  row = 40'h4649494931;
      7'd84:  row = 40'h01017F0101;
      7'd85:  row = 40'h3F4040403F;
      7'd86:  row = 40'h1F2040201F;
      7'd87:  row = 40'h7F2018207F;
      7'd88:  row = 40'h6314081463;
      7'd89:  row = 40'h0304780403;
      7'd90:  row = 40'h6151494543;
      7'd91:  row = 40'h00007F4141;
      7'd92:  row = 40'h0204081020;
      7'd93:  row = 40'h41417F0000;
      7'd94:  row = 40'h0402010204;
      7'd95:  row = 40'h4040404040;
      7'd96:  row = 40'h0001020400;
      7'd97:  row = 40'h2054545478;
      7'd98:  row = 40'h7F48444438;
      7'd99:  row = 40'h3844444420;
      7'd100: row = 40'h384444487F;
      7'd101: row = 40'h3854545418;
      7'd102: row = 40'h087E090102;
      7'd103: row = 40'h081454543C;
      7'd104: row = 40'h7F08040478;
      7'd105: row = 40'h00447D4000;
      7'd106: row = 40'h2040443D00;
      7'd107: row = 40'h007F102844;
      7'd108: row = 40'h00417F4000;
      7'd109: row = 40'h7C04180478;
      7'd110: row = 40'h7C08040478;
      7'd111: row = 40'h3844444438;
      7'd112: row = 40'h7C14141408;
      7'd113: row = 40'h081414187C;
      7'd114: row = 40'h7C08040408;
      7'd115: row = 40'h4854545420;
      7'd116: row = 40'h043F444020;
      7'd117: row = 40'h3C4040207C;
      7'd118: row = 40'h1C2040201C;
      7'd119: row = 40'h3C4030403C;
      7'd120: row = 40'h4428102844;
      7'd121: row = 40'h0C5050503C;
      7'd122: row = 40'h4464544C44;
      7'd123: row = 40'h0008364100;
      7'd124: row = 40'h00007F0000;
      7'd125: row = 40'h0041360800;
      7'd126: row = 40'h08082A1C08;
      7'd127: row = 40'h081C2A0808;
      default: row = '0;
    endcase
    return row;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/fbgw_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module fbgw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ hw/rtl/fbgw_seq.sv @@
// Command sequencer: clear sweep, glyph read-modify-write and segment readout.
`timescale 1ns / 1ps
`default_nettype none

module fbgw_seq import fbgw_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [1:0] command_i,
  input  wire logic [6:0] pos_x_i,
  input  wire logic [5:0] pos_y_i,
  input  wire logic [6:0] char_code_i,
  input  wire logic [2:0] seg_page_i,
  input  wire logic       seg_half_i,
  output ram_req_t        ram_req_o,
  input  wire logic [7:0] rdata_i,
  input  wire logic       out_free_i,
  output logic            res_valid_o,
  output res_t            res_o
);

  state_e state_q, state_d;

  logic [6:0]        x_q, x_d;
  logic [2:0]        page_q, page_d;
  logic [2:0]        shift_q, shift_d;
  logic [FONT_W-1:0] glyph_q, glyph_d;
  logic [2:0]        k_q, k_d;
  logic              part_q, part_d;
  logic [ADDR_W-1:0] clr_addr_q, clr_addr_d;
  logic [2:0]        seg_page_q, seg_page_d;
  logic              seg_half_q, seg_half_d;
  logic [HC_W-1:0]   segc_q, segc_d;
  logic              rd_ok_q, rd_ok_d;
  logic              pend_q, pend_d;
  logic [ADDR_W-1:0] pend_addr_q, pend_addr_d;
  logic [7:0]        pend_keep_q, pend_keep_d;
  logic [7:0]        pend_set_q, pend_set_d;

  logic        code_ok;
  logic [7:0]  g;
  logic [15:0] wide;
  logic [7:0]  mask;
  logic [8:0]  draw_col;
  logic [3:0]  draw_page;
  logic        draw_ok;
  logic        last_step;
  logic [SC_W-1:0] seg_col;
  logic        seg_ok;
  logic        seg_last;

  assign code_ok   = char_code_i >= 7'(FIRST_CODE);
  assign g         = glyph_q[FONT_W - 1 - 8 * k_q -: 8];
  assign wide      = {8'h00, g} << shift_q;
  assign mask      = 8'hFF << shift_q;
  assign draw_col  = {2'b00, x_q} + {6'b000000, k_q};
  assign draw_page = part_q ? ({1'b0, page_q} + 4'd1) : {1'b0, page_q};
  assign draw_ok   = (32'(draw_page) < PAGE_COUNT) && (32'(draw_col) < SCREEN_WIDTH);
  // The lower page is only touched when pos_y is not a multiple of 8.
  assign last_step = (k_q == 3'(GLYPH_COLS - 1)) && (part_q || (shift_q == 3'd0));
  assign seg_col   = seg_half_q ? (SC_W'(HALF_COLUMNS) + SC_W'(segc_q)) : SC_W'(segc_q);
  assign seg_ok    = (32'(seg_page_q) < PAGE_COUNT) && (32'(seg_col) < SCREEN_WIDTH);
  assign seg_last  = segc_q == HC_W'(HALF_COLUMNS - 1);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          case (cmd_e'(command_i))
            CMD_CLEAR: state_d = S_CLEAR;
            CMD_PUT:   state_d = code_ok ? S_DRAW : S_DONE;
            CMD_SEG:   state_d = S_SEG_RD;
            default:   state_d = S_IDLE;
          endcase
        end
      end
      S_CLEAR: begin
        if (clr_addr_q == ADDR_W'(STORE_DEPTH - 1)) begin
          state_d = S_DONE;
        end
      end
      S_DRAW: begin
        if (last_step) begin
          state_d = S_DONE;
        end
      end
      S_SEG_RD: state_d = S_SEG_OUT;
      S_SEG_OUT: begin
        if (out_free_i) begin
          state_d = seg_last ? S_IDLE : S_SEG_RD;
        end
      end
      S_DONE: begin
        if (out_free_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o  = (state_q == S_IDLE);
    res_valid_o = 1'b0;
    res_o       = '0;

    x_d         = x_q;
    page_d      = page_q;
    shift_d     = shift_q;
    glyph_d     = glyph_q;
    k_d         = k_q;
    part_d      = part_q;
    clr_addr_d  = clr_addr_q;
    seg_page_d  = seg_page_q;
    seg_half_d  = seg_half_q;
    segc_d      = segc_q;
    rd_ok_d     = rd_ok_q;
    pend_d      = 1'b0;
    pend_addr_d = store_addr(draw_page, draw_col);
    pend_keep_d = (shift_q == 3'd0) ? 8'h80 : (part_q ? mask : ~mask);
    pend_set_d  = part_q ? wide[15:8] : wide[7:0];

    // The write half of a read-modify-write lands in the cycle after its read.
    ram_req_o.we    = pend_q;
    ram_req_o.waddr = pend_addr_q;
    ram_req_o.wdata = (rdata_i & pend_keep_q) | pend_set_q;
    ram_req_o.re    = 1'b0;
    ram_req_o.raddr = store_addr(draw_page, draw_col);

    case (state_q)
      S_IDLE: begin
        x_d        = pos_x_i;
        page_d     = pos_y_i[5:3];
        shift_d    = pos_y_i[2:0];
        glyph_d    = font_row(char_code_i);
        k_d        = '0;
        part_d     = 1'b0;
        clr_addr_d = '0;
        seg_page_d = seg_page_i;
        seg_half_d = seg_half_i;
        segc_d     = '0;
      end
      S_CLEAR: begin
        ram_req_o.we    = 1'b1;
        ram_req_o.waddr = clr_addr_q;
        ram_req_o.wdata = 8'h00;
        clr_addr_d      = clr_addr_q + ADDR_W'(1);
      end
      S_DRAW: begin
        ram_req_o.re = draw_ok;
        pend_d       = draw_ok;
        if (!part_q && (shift_q != 3'd0)) begin
          part_d = 1'b1;
        end else begin
          part_d = 1'b0;
          k_d    = k_q + 3'd1;
        end
      end
      S_SEG_RD: begin
        ram_req_o.re    = seg_ok;
        ram_req_o.raddr = store_addr({1'b0, seg_page_q}, 9'(seg_col));
        rd_ok_d         = seg_ok;
      end
      S_SEG_OUT: begin
        if (out_free_i) begin
          res_valid_o      = 1'b1;
          res_o.pixel_byte = rd_ok_q ? rdata_i : 8'h00;
          res_o.page       = seg_page_q;
          res_o.half       = seg_half_q;
          res_o.column     = 6'(segc_q);
          res_o.last       = seg_last;
          segc_d           = segc_q + HC_W'(1);
        end
      end
      S_DONE: begin
        if (out_free_i) begin
          res_valid_o = 1'b1;
          res_o.last  = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q         <= x_d;
    page_q      <= page_d;
    shift_q     <= shift_d;
    glyph_q     <= glyph_d;
    k_q         <= k_d;
    part_q      <= part_d;
    clr_addr_q  <= clr_addr_d;
    seg_page_q  <= seg_page_d;
    seg_half_q  <= seg_half_d;
    segc_q      <= segc_d;
    rd_ok_q     <= rd_ok_d;
    pend_addr_q <= pend_addr_d;
    pend_keep_q <= pend_keep_d;
    pend_set_q  <= pend_set_d;
  end

endmodule

`default_nettype wire

@@ hw/rtl/page_framebuffer_glyph_writer.sv @@
// Top level of the page framebuffer glyph writer with its result register.
`timescale 1ns / 1ps
`default_nettype none

// A 1024-byte frame store (8 pages of 128 columns, bit 0 is the top pixel of
// each byte) sits in one RAM with a write port and a registered read port.
// Clear writes every byte once, then returns one done item.
// Put character draws a 5x7 glyph with one store read-modify-write per cycle:
// 5 steps when pos_y is a multiple of 8 and 10 steps otherwise, then one done
// item; codes below 32 draw nothing. Read segment returns 64 bytes, each with
// a RAM read and then a hand-off to the output register that waits until the
// register is free. The store holds garbage after reset until the first clear.
// One item is worked at a time; the next is taken as soon as the last result
// sits in the output register.
module page_framebuffer_glyph_writer import fbgw_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [1:0] command_i,
  input  wire logic [6:0] pos_x_i,
  input  wire logic [5:0] pos_y_i,
  input  wire logic [6:0] char_code_i,
  input  wire logic [2:0] seg_page_i,
  input  wire logic       seg_half_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      pixel_byte_o,
  output logic [2:0]      out_page_o,
  output logic            out_half_o,
  output logic [5:0]      out_column_o,
  output logic            last_o
);

  ram_req_t   ram_req;
  logic [7:0] rdata;
  logic       res_valid;
  res_t       res;
  logic       out_free;
  logic       out_valid_q, out_valid_d;
  res_t       out_q;

  assign out_free = !out_valid_q || out_ready_i;

  fbgw_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .command_i   (command_i),
    .pos_x_i     (pos_x_i),
    .pos_y_i     (pos_y_i),
    .char_code_i (char_code_i),
    .seg_page_i  (seg_page_i),
    .seg_half_i  (seg_half_i),
    .ram_req_o   (ram_req),
    .rdata_i     (rdata),
    .out_free_i  (out_free),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  fbgw_ram #(
    .WIDTH (8),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.wdata),
    .re_i    (ram_req.re),
    .raddr_i (ram_req.raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign pixel_byte_o = out_q.pixel_byte;
  assign out_page_o   = out_q.page;
  assign out_half_o   = out_q.half;
  assign out_column_o = out_q.column;
  assign last_o       = out_q.last;

  // A new result must never overwrite one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten");

  // Within one item the read and the write of a cycle never target the same byte.
  a_no_rw_collision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_req.we && ram_req.re) |-> (ram_req.waddr != ram_req.raddr))
    else $error("store read and write collide");

  // All store writes of an item are finished before the next item is taken.
  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !ram_req.we)
    else $error("store write pending while ready");

endmodule

`default_nettype wire
